FILE: sv/sorted_deadline_timer_queue_macros.svh
// Assertion macros for the sorted deadline timer queue.
// Expects clk and rst_n in the scope of each use.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/stq_pkg.sv
// Types and codes shared by the sorted deadline timer queue.
// No dependencies.
package stq_pkg;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_DEL = 2'd1;
  localparam logic [1:0] FUNC_SVC = 2'd2;
  localparam logic [1:0] FUNC_QRY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_TMO  = 2'd1;
  localparam logic [1:0] ST_ARMED     = 2'd2;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] REG_MIN_PERIOD = 3'd0;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [63:0] deadline_in;
    logic [63:0] interval;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  fired_slot;
    logic [1:0]  status;
    logic        program_timer;
    logic [63:0] next_deadline;
    logic        is_expired;
    logic [63:0] remaining;
    logic        is_armed;
    logic        last;
  } out_item_t;

endpackage

FILE: sv/stq_chan_if.sv
// Valid/ready channel carrying one payload of a given type.
// Used with stq_pkg item types.
interface stq_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: slot store, sorted order list and sequencer.
// Depends on stq_pkg, stq_chan_if and sorted_deadline_timer_queue_macros.svh.
//
//   channel | direction | payload    | transaction
//   in_ch   | in        | in_item_t  | in_ch.valid & in_ch.ready
//   out_ch  | out       | out_item_t | out_ch.valid & out_ch.ready
//   cfg     | in        | min_period | psel & penable & pwrite (pready tied high)
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Delete, query, a rejected add or a service of an empty queue step through dispatch,
// status build, status output and back to idle.
// An accepted add also steps past each earlier entry in the scan before it inserts.
// Service adds a check step per slot examined and, per fired slot, an advance step, its
// expiry transaction and, on re-arm, the scan and insert steps of an add.
// Each result waits in the output register, and the sequencer holds, until out_ch takes it.
// Reset (rst_n low, synchronous) empties the queue and zeroes all slot timeouts at once.
`include "sorted_deadline_timer_queue_macros.svh"
module sorted_deadline_timer_queue #(
  parameter int NUM_SLOTS   = 16,
  parameter int MAX_ACTIONS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  stq_chan_if.sink    in_ch,
  stq_chan_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stq_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int TW = $clog2(MAX_ACTIONS + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;
  localparam logic [2:0] S_INS     = 3'd2;
  localparam logic [2:0] S_SVC     = 3'd3;
  localparam logic [2:0] S_SVC_ADV = 3'd4;
  localparam logic [2:0] S_FINAL   = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  // configuration
  logic [31:0] min_period_r;

  // slot store and sorted order
  logic [63:0]   timeout_r [NUM_SLOTS];
  logic [63:0]   period_r  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] periodic_r;
  logic [NUM_SLOTS-1:0] linked_r;
  logic [SW-1:0] order_r   [NUM_SLOTS];
  logic [CW-1:0] count_r;

  // sequencer
  logic [2:0]    state_r;
  logic [2:0]    ins_ret_r;
  logic [2:0]    out_ret_r;
  in_item_t      item_r;
  logic [SW-1:0] ins_slot_r;
  logic [CW-1:0] ins_pos_r;
  logic [SW-1:0] pos_r;
  logic [SW-1:0] nxt_r;
  logic          have_next_r;
  logic [TW-1:0] tries_r;
  out_item_t     fin_r;
  out_item_t     out_r;
  logic          out_valid_r;

  // decoded item
  logic          slot_ok;
  logic [SW-1:0] sidx;
  assign slot_ok = 32'(item_r.slot) < 32'(NUM_SLOTS);
  assign sidx    = SW'(item_r.slot);

  // find the position of the slot to unlink: pos_r in service, the item's slot otherwise
  logic [SW-1:0] unl_tgt;
  logic [CW-1:0] unl_p;
  logic          unl_found;
  assign unl_tgt = (state_r == S_SVC) ? pos_r : sidx;
  always_comb begin
    unl_p     = count_r;
    unl_found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!unl_found && CW'(i) < count_r && order_r[i] == unl_tgt) begin
        unl_p     = CW'(i);
        unl_found = 1'b1;
      end
    end
  end

  // shared comparator for the insertion scan
  logic [63:0] scan_tmo;
  logic        scan_less;
  assign scan_tmo  = timeout_r[order_r[SW'(ins_pos_r)]];
  assign scan_less = (ins_pos_r < count_r) && (scan_tmo < timeout_r[ins_slot_r]);

  // service step: neighbour of the cursor and the expiry test
  logic [CW:0]   svc_p1;
  logic          svc_have_next;
  logic [SW-1:0] svc_nxt;
  logic [TW-1:0] tries_nxt;
  logic [63:0]   pos_tmo;
  logic          svc_fire;
  assign svc_p1        = {1'b0, unl_p} + 1'b1;
  assign svc_have_next = svc_p1 < {1'b0, count_r};
  assign svc_nxt       = svc_have_next ? order_r[SW'(svc_p1)] : '0;
  assign tries_nxt     = tries_r - 1'b1;
  assign pos_tmo       = timeout_r[pos_r];
  assign svc_fire      = (pos_tmo <= item_r.now) && (tries_nxt != '0);

  // query and head
  logic [63:0] q_tmo;
  logic [63:0] head_tmo;
  assign q_tmo    = timeout_r[sidx];
  assign head_tmo = (count_r != '0) ? timeout_r[order_r[0]] : 64'd0;

  // configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_PERIOD) ? min_period_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= 32'd0;
    end else if (cfg_wr && paddr == REG_MIN_PERIOD) begin
      min_period_r <= pwdata;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ins_ret_r   <= S_IDLE;
      out_ret_r   <= S_IDLE;
      count_r     <= '0;
      linked_r    <= '0;
      periodic_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        timeout_r[i] <= 64'd0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r  <= in_ch.data;
            state_r <= S_DISP;
          end
        end

        S_DISP: begin
          out_item_t  fin;
          logic [2:0] disp_nxt;
          fin      = '0;
          disp_nxt = S_FINAL;
          unique case (item_r.func)
            FUNC_ADD: begin
              if (item_r.deadline_in == 64'd0) begin
                fin.status = ST_ZERO_TMO;
              end else if (slot_ok && linked_r[sidx]) begin
                fin.status = ST_ARMED;
              end else if (slot_ok) begin
                // arm the slot, then scan for its place
                timeout_r[sidx]  <= item_r.deadline_in;
                periodic_r[sidx] <= (item_r.interval != 64'd0);
                if (item_r.interval != 64'd0 && item_r.interval < {32'd0, min_period_r})
                  period_r[sidx] <= {32'd0, min_period_r};
                else
                  period_r[sidx] <= item_r.interval;
                ins_slot_r <= sidx;
                ins_pos_r  <= '0;
                ins_ret_r  <= S_FINAL;
                disp_nxt   = S_INS;
              end
            end
            FUNC_DEL: begin
              if (slot_ok && linked_r[sidx] && unl_found) begin
                for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                  if (CW'(i) >= unl_p) order_r[i] <= order_r[i+1];
                end
                count_r        <= count_r - 1'b1;
                linked_r[sidx] <= 1'b0;
              end
            end
            FUNC_SVC: begin
              if (count_r != '0) begin
                pos_r    <= order_r[0];
                tries_r  <= TW'(MAX_ACTIONS);
                disp_nxt = S_SVC;
              end
            end
            FUNC_QRY: begin
              if (slot_ok) begin
                fin.is_armed = linked_r[sidx];
                if (q_tmo != 64'd0 && item_r.now < q_tmo) begin
                  fin.remaining = q_tmo - item_r.now;
                end else begin
                  fin.is_expired = 1'b1;
                end
              end
            end
            default: ;
          endcase
          fin_r   <= fin;
          state_r <= disp_nxt;
        end

        S_INS: begin
          if (count_r >= CW'(NUM_SLOTS)) begin
            state_r <= ins_ret_r;
          end else if (scan_less) begin
            ins_pos_r <= ins_pos_r + 1'b1;
          end else begin
            // open a gap at the scan position and drop the slot in
            for (int i = 1; i < NUM_SLOTS; i++) begin
              if (CW'(i) > ins_pos_r) order_r[i] <= order_r[i-1];
            end
            order_r[SW'(ins_pos_r)] <= ins_slot_r;
            count_r                 <= count_r + 1'b1;
            linked_r[ins_slot_r]    <= 1'b1;
            if (ins_ret_r == S_FINAL) fin_r.program_timer <= (ins_pos_r == '0);
            state_r <= ins_ret_r;
          end
        end

        S_SVC: begin
          tries_r     <= tries_nxt;
          have_next_r <= svc_have_next;
          nxt_r       <= svc_nxt;
          if (!svc_fire) begin
            state_r <= S_FINAL;
          end else begin
            logic [2:0] after;
            out_item_t  exp_item;
            after = periodic_r[pos_r] ? S_INS : S_SVC_ADV;
            exp_item            = '0;
            exp_item.kind       = KIND_EXPIRY;
            exp_item.fired_slot = 4'(pos_r);
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
              if (CW'(i) >= unl_p) order_r[i] <= order_r[i+1];
            end
            count_r         <= count_r - 1'b1;
            linked_r[pos_r] <= 1'b0;
            if (periodic_r[pos_r]) begin
              timeout_r[pos_r] <= pos_tmo + period_r[pos_r];
              ins_slot_r       <= pos_r;
              ins_pos_r        <= '0;
              ins_ret_r        <= S_SVC_ADV;
            end else begin
              timeout_r[pos_r] <= 64'd0;
            end
            // a timeout that wrapped to zero is serviced silently
            if (pos_tmo != 64'd0) begin
              out_r       <= exp_item;
              out_valid_r <= 1'b1;
              out_ret_r   <= after;
              state_r     <= S_OUT;
            end else begin
              state_r <= after;
            end
          end
        end

        S_SVC_ADV: begin
          pos_r   <= nxt_r;
          state_r <= have_next_r ? S_SVC : S_FINAL;
        end

        S_FINAL: begin
          out_item_t st_item;
          st_item               = fin_r;
          st_item.kind          = KIND_STATUS;
          st_item.fired_slot    = item_r.slot;
          st_item.next_deadline = head_tmo;
          st_item.last          = 1'b1;
          if (item_r.func == FUNC_SVC) st_item.program_timer = (count_r != '0);
          out_r       <= st_item;
          out_valid_r <= 1'b1;
          out_ret_r   <= S_IDLE;
          state_r     <= S_OUT;
        end

        S_OUT: begin
          // hold the result until the sink takes it
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= out_ret_r;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  `STQ_ASSERT_NOW(a_count_matches_links, 1'b1, $countones(linked_r) == 32'(count_r), "queue count and link flags disagree")
  `STQ_ASSERT_NOW(a_no_accept_while_busy, in_ch.valid && in_ch.ready, !out_valid_r, "item accepted with a result pending")
  `STQ_ASSERT_NEXT(a_last_frees_block, out_valid_r && out_ch.ready && out_r.last, in_ch.ready, "block not idle after final status")
  `STQ_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_r) <= 32'(NUM_SLOTS), "queue count beyond slot count")

endmodule
